// ----- rtl/printf_conversion_formatter_assert.svh -----
// assertion macros shared by the formatter modules
// expects clk_i and rst_ni to be visible in the including module
`ifndef PRINTF_CONVERSION_FORMATTER_ASSERT_SVH
`define PRINTF_CONVERSION_FORMATTER_ASSERT_SVH

// same-cycle implication
`define PCF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcf check failed");

// next-cycle implication
`define PCF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcf check failed");

`endif

// ----- rtl/pcf_pkg.sv -----
// shared types, codes and digit table for the printf conversion formatter
// no dependencies
`default_nettype none

package pcf_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_WIDTH_DEF  = 60;

  // counts of characters and digits, bounded by the parameter ranges
  localparam int CNT_W = 8;

  localparam logic [3:0] CMD_DEC   = 4'd0;
  localparam logic [3:0] CMD_UDEC  = 4'd1;
  localparam logic [3:0] CMD_HEX_L = 4'd2;
  localparam logic [3:0] CMD_HEX_U = 4'd3;
  localparam logic [3:0] CMD_PTR   = 4'd4;
  localparam logic [3:0] CMD_BIN   = 4'd5;
  localparam logic [3:0] CMD_CHR   = 4'd6;
  localparam logic [3:0] CMD_PCT   = 4'd7;

  typedef struct packed {
    logic load;
    logic mode_dec;
    logic mode_hex;
    logic shift_dig;
    logic shift_bin;
  } pcf_conv_ctl_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] len;
  } pcf_conv_st_t;

  typedef struct packed {
    logic shift_dig;
    logic shift_bin;
  } pcf_shift_t;

  typedef struct packed {
    logic [3:0]       cmd;
    logic [5:0]       width;
    logic             zf;
    logic             lj;
    logic             neg;
    logic [7:0]       other;
    logic [7:0]       chr;
    logic [CNT_W-1:0] len;
  } pcf_plan_t;

  typedef struct packed {
    logic active;
  } pcf_emit_st_t;

  // one digit of 0..15 as ascii, lower or upper case letters
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else if (upper) begin
      c = 8'h41 + {4'd0, d} - 8'd10;
    end else begin
      c = 8'h61 + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pcf_conv.sv -----
// digit unit: bit-serial binary to bcd (shift and add 3), hex nibble
// alignment and leading zero skip; uses pcf_pkg
`default_nettype none
`include "printf_conversion_formatter_assert.svh"

module pcf_conv #(
  parameter int VALUE_BITS = pcf_pkg::VALUE_BITS_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  pcf_pkg::pcf_conv_ctl_t ctl_i,
  input  wire  [VALUE_BITS-1:0] val_i,
  output pcf_pkg::pcf_conv_st_t  st_o,
  output logic [3:0]            digit_o,
  output logic                  bit_o
);

  localparam int NDIG   = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int DW     = NDIG * 4;
  localparam int HDIG   = (VALUE_BITS + 3) / 4;
  localparam int HW     = HDIG * 4;
  localparam int HEX_SH = DW - HW;
  localparam int CW     = $clog2(VALUE_BITS);

  typedef enum logic [3:0] {
    C_IDLE   = 4'b0001,
    C_DABBLE = 4'b0010,
    C_SKIP   = 4'b0100,
    C_READY  = 4'b1000
  } conv_state_e;

  conv_state_e             state_q, state_d;
  logic [DW-1:0]           dig_q, dig_d;
  logic [VALUE_BITS-1:0]   bin_q, bin_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [pcf_pkg::CNT_W-1:0] len_q, len_d;
  logic [DW-1:0]           adj;
  logic [HW-1:0]           hexv;

  // add 3 to every bcd digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*4 +: 4] = (dig_q[i*4 +: 4] >= 4'd5) ? dig_q[i*4 +: 4] + 4'd3 : dig_q[i*4 +: 4];
    end
  end

  assign hexv = HW'(val_i);

  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    bin_d   = bin_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    if (ctl_i.load) begin
      bin_d = val_i;
      cnt_d = CW'(VALUE_BITS - 1);
      if (ctl_i.mode_dec) begin
        dig_d   = '0;
        len_d   = '0;
        state_d = C_DABBLE;
      end else if (ctl_i.mode_hex) begin
        // most significant nibble at the top of the digit register
        dig_d   = DW'(hexv) << HEX_SH;
        len_d   = pcf_pkg::CNT_W'(HDIG);
        state_d = C_SKIP;
      end else begin
        dig_d   = '0;
        len_d   = '0;
        state_d = C_READY;
      end
    end else begin
      case (state_q)
        C_DABBLE: begin
          dig_d = {adj[DW-2:0], bin_q[VALUE_BITS-1]};
          bin_d = bin_q << 1;
          if (cnt_q == '0) begin
            len_d   = pcf_pkg::CNT_W'(NDIG);
            state_d = C_SKIP;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
        C_SKIP: begin
          // drop leading zeros, keep at least one digit
          if (dig_q[DW-1 -: 4] == 4'd0 && len_q > pcf_pkg::CNT_W'(1)) begin
            dig_d = dig_q << 4;
            len_d = len_q - 1'b1;
          end else begin
            state_d = C_READY;
          end
        end
        C_READY: begin
          if (ctl_i.shift_dig) begin
            dig_d = dig_q << 4;
          end
          if (ctl_i.shift_bin) begin
            bin_d = bin_q >> 1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    bin_q <= bin_d;
    cnt_q <= cnt_d;
    len_q <= len_d;
  end

  assign st_o.done = (state_q == C_READY);
  assign st_o.len  = len_q;
  assign digit_o   = dig_q[DW-1 -: 4];
  assign bit_o     = bin_q[0];

  `PCF_ASSERT_IMP(a_shift_ready, ctl_i.shift_dig || ctl_i.shift_bin, state_q == C_READY)
  `PCF_ASSERT_IMP(a_skip_len, state_q == C_SKIP, len_q != '0)
  `PCF_ASSERT_NXT(a_dabble_end, state_q == C_DABBLE && cnt_q == '0 && !ctl_i.load,
                  state_q == C_SKIP)

endmodule

`default_nettype wire

// ----- rtl/pcf_emit.sv -----
// character sequencer: field layout, output register and one character
// per cycle unless stalled (prefix, sign, padding, body); uses pcf_pkg
`default_nettype none
`include "printf_conversion_formatter_assert.svh"

module pcf_emit #(
  parameter int VALUE_BITS = pcf_pkg::VALUE_BITS_DEF,
  parameter int MAX_WIDTH  = pcf_pkg::MAX_WIDTH_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  pcf_pkg::pcf_plan_t    plan_i,
  input  wire  [3:0]            digit_i,
  input  wire                   bit_i,
  output pcf_pkg::pcf_shift_t   shift_o,
  output pcf_pkg::pcf_emit_st_t st_o,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic [7:0]            out_char_o,
  output logic                  last_o
);

  localparam int CW          = pcf_pkg::CNT_W;
  localparam int MAX_RESULTS = MAX_WIDTH + 2;
  localparam int PTR_DIGITS  = (VALUE_BITS + 3) / 4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  // layout from the plan
  logic [5:0]      width_c;
  logic [CW-1:0]   w, blen, npre, wsel, binlen, pad, lpad, rpad, tot, totc;
  logic [CW-1:0]   b1, b2, b3, b4, b5;
  logic signed [CW:0] padv;
  logic            zfe, s1, s2;
  logic [7:0]      pre0, pre1;

  logic [CW-1:0]   b1_q, b2_q, b3_q, b4_q, b5_q, last_idx_q, idx_q;
  logic [7:0]      pre0_q, pre1_q, padc_q;
  logic            binmode_q, upper_q, active_q;
  logic            out_valid_q;
  logic [7:0]      out_char_q;
  logic            out_last_q;

  logic            fire, is_last, in_body;
  logic [7:0]      ch;

  assign width_c = (plan_i.width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : plan_i.width;

  always_comb begin
    wsel = (width_c == 6'd0) ? CW'(VALUE_BITS) : CW'(width_c);
    binlen = wsel;
    if (binlen > CW'(VALUE_BITS)) begin
      binlen = CW'(VALUE_BITS);
    end
    if (binlen > CW'(MAX_RESULTS)) begin
      binlen = CW'(MAX_RESULTS);
    end
  end

  always_comb begin
    npre = '0;
    w    = CW'(width_c);
    blen = plan_i.len;
    zfe  = plan_i.zf;
    pre0 = CH_PCT;
    pre1 = plan_i.other;
    case (plan_i.cmd)
      pcf_pkg::CMD_DEC, pcf_pkg::CMD_UDEC, pcf_pkg::CMD_HEX_L, pcf_pkg::CMD_HEX_U: begin
      end
      pcf_pkg::CMD_PTR: begin
        npre = CW'(2);
        w    = CW'(PTR_DIGITS);
        zfe  = 1'b1;
        pre0 = CH_ZERO;
        pre1 = CH_X;
      end
      pcf_pkg::CMD_BIN: begin
        blen = binlen;
        w    = binlen;
      end
      pcf_pkg::CMD_CHR: begin
        npre = CW'(1);
        w    = '0;
        blen = '0;
        pre0 = plan_i.chr;
      end
      pcf_pkg::CMD_PCT: begin
        npre = CW'(1);
        blen = '0;
      end
      default: begin
        // unknown conversion echoes percent and its character
        npre = CW'(2);
        blen = '0;
      end
    endcase
  end

  always_comb begin
    padv = $signed({1'b0, w}) - $signed({1'b0, blen}) - $signed({{CW{1'b0}}, plan_i.neg});
    pad  = padv[CW] ? '0 : padv[CW-1:0];
    s1   = plan_i.neg & zfe;
    s2   = plan_i.neg & ~zfe;
    lpad = plan_i.lj ? '0 : pad;
    rpad = plan_i.lj ? pad : '0;
    b1   = npre;
    b2   = b1 + CW'(s1);
    b3   = b2 + lpad;
    b4   = b3 + CW'(s2);
    b5   = b4 + blen;
    tot  = b5 + rpad;
    totc = (tot > CW'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : tot;
  end

  // character at the current index
  always_comb begin
    in_body = 1'b0;
    if (idx_q < b1_q) begin
      ch = (idx_q == '0) ? pre0_q : pre1_q;
    end else if (idx_q < b2_q) begin
      ch = CH_MINUS;
    end else if (idx_q < b3_q) begin
      ch = padc_q;
    end else if (idx_q < b4_q) begin
      ch = CH_MINUS;
    end else if (idx_q < b5_q) begin
      in_body = 1'b1;
      if (binmode_q) begin
        ch = bit_i ? CH_ONE : CH_DOT;
      end else begin
        ch = pcf_pkg::digit_char(digit_i, upper_q);
      end
    end else begin
      ch = CH_SPACE;
    end
  end

  assign fire    = active_q && (!out_valid_q || !out_stall_i);
  assign is_last = (idx_q == last_idx_q);

  assign shift_o.shift_dig = fire && in_body && !binmode_q;
  assign shift_o.shift_bin = fire && in_body && binmode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (start_i) begin
        active_q <= 1'b1;
      end else if (fire && is_last) begin
        active_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      b1_q       <= b1;
      b2_q       <= b2;
      b3_q       <= b3;
      b4_q       <= b4;
      b5_q       <= b5;
      last_idx_q <= totc - 1'b1;
      pre0_q     <= pre0;
      pre1_q     <= pre1;
      padc_q     <= zfe ? CH_ZERO : CH_SPACE;
      binmode_q  <= (plan_i.cmd == pcf_pkg::CMD_BIN);
      upper_q    <= (plan_i.cmd == pcf_pkg::CMD_HEX_U);
      idx_q      <= '0;
    end else if (fire) begin
      idx_q <= idx_q + 1'b1;
    end
    if (fire) begin
      out_char_q <= ch;
      out_last_q <= is_last;
    end
  end

  assign st_o.active = active_q;
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;

  `PCF_ASSERT_IMP(a_idx_bound, active_q, idx_q <= last_idx_q)
  `PCF_ASSERT_IMP(a_count_cap, active_q, last_idx_q < CW'(MAX_RESULTS))
  `PCF_ASSERT_NXT(a_last_ends, fire && is_last && !start_i, !active_q && out_last_q)

endmodule

`default_nettype wire

// ----- rtl/printf_conversion_formatter.sv -----
// Formats one parsed printf conversion into a stream of ascii characters.
// Input channel: in_valid_i / in_stall_o carry cmd, value, width, zpad,
// left_justify and other_char; an item is taken when valid is high and stall
// is low. One item is worked on at a time: stall stays high from acceptance
// until the state machine returns to idle, which it does in the cycle after
// the final character of that item is loaded. Output channel: out_valid_o /
// out_stall_i carry out_char_o and last_o, one character per transfer,
// last_o marking the final character of the conversion. Binary, char,
// percent and unknown kinds start the sequencer once the conversion unit
// is ready. Hex and pointer first drop leading zeros at one nibble per
// cycle; decimal kinds first run the bit-serial bcd converter, then drop
// leading zeros the same way. Then one character per cycle while the
// receiver does not stall, at most MAX_WIDTH+2 characters. The next item
// is taken only after the state machine has returned to idle following
// the last character.
// A stalled receiver holds the output register and pauses the sequencer.
// Reset clears the sequencer and the output valid; no item is in flight.
// Depends on pcf_pkg, pcf_conv and pcf_emit.
`default_nettype none
`include "printf_conversion_formatter_assert.svh"

module printf_conversion_formatter #(
  parameter int VALUE_BITS = pcf_pkg::VALUE_BITS_DEF,
  parameter int MAX_WIDTH  = pcf_pkg::MAX_WIDTH_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [3:0] cmd_i,
  input  wire  [31:0] value_i,
  input  wire  [5:0] width_i,
  input  wire        zpad_i,
  input  wire        left_justify_i,
  input  wire  [7:0] other_char_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [7:0] out_char_o,
  output logic       last_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic                    accept, neg, start;
  logic [VALUE_BITS-1:0]   val, mag;

  logic [3:0]              cmd_q;
  logic [5:0]              width_q;
  logic                    zf_q, lj_q, neg_q;
  logic [7:0]              other_q, chr_q;

  pcf_pkg::pcf_conv_ctl_t  conv_ctl;
  pcf_pkg::pcf_conv_st_t   conv_st;
  pcf_pkg::pcf_shift_t     shift;
  pcf_pkg::pcf_emit_st_t   emit_st;
  pcf_pkg::pcf_plan_t      plan;
  logic [3:0]              digit;
  logic                    bit_val;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // value masked to the configured width; magnitude for negative decimals
  assign val = VALUE_BITS'(value_i);
  assign neg = (cmd_i == pcf_pkg::CMD_DEC) && val[VALUE_BITS-1];
  assign mag = neg ? (~val + VALUE_BITS'(1)) : val;

  always_comb begin
    conv_ctl.load      = accept;
    conv_ctl.mode_dec  = cmd_i inside {pcf_pkg::CMD_DEC, pcf_pkg::CMD_UDEC};
    conv_ctl.mode_hex  = cmd_i inside {pcf_pkg::CMD_HEX_L, pcf_pkg::CMD_HEX_U,
                                       pcf_pkg::CMD_PTR};
    conv_ctl.shift_dig = shift.shift_dig;
    conv_ctl.shift_bin = shift.shift_bin;
  end

  always_comb begin
    state_d = state_q;
    start   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        if (conv_st.done) begin
          start   = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!emit_st.active) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      width_q <= width_i;
      zf_q    <= zpad_i;
      lj_q    <= left_justify_i;
      neg_q   <= neg;
      other_q <= other_char_i;
      chr_q   <= value_i[7:0];
    end
  end

  always_comb begin
    plan.cmd   = cmd_q;
    plan.width = width_q;
    plan.zf    = zf_q;
    plan.lj    = lj_q;
    plan.neg   = neg_q;
    plan.other = other_q;
    plan.chr   = chr_q;
    plan.len   = conv_st.len;
  end

  pcf_conv #(
    .VALUE_BITS(VALUE_BITS)
  ) u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (conv_ctl),
    .val_i  (mag),
    .st_o   (conv_st),
    .digit_o(digit),
    .bit_o  (bit_val)
  );

  pcf_emit #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .plan_i     (plan),
    .digit_i    (digit),
    .bit_i      (bit_val),
    .shift_o    (shift),
    .st_o       (emit_st),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_char_o (out_char_o),
    .last_o     (last_o)
  );

  `PCF_ASSERT_NXT(a_accept_conv, accept, state_q == S_CONV)
  `PCF_ASSERT_IMP(a_emit_owned, emit_st.active, state_q == S_EMIT)
  `PCF_ASSERT_IMP(a_conv_held, state_q == S_EMIT, conv_st.done)

endmodule

`default_nettype wire

// ----- sim/printf_conversion_formatter_tb.sv -----
// self-checking testbench for printf_conversion_formatter: directed and random conversions
// with random idling on both channels; expected characters come from a local formatter model
// depends on pcf_pkg and the formatter rtl

module printf_conversion_formatter_tb;

  localparam logic [3:0] CMD_OTHER = 4'd8;
  localparam logic [3:0] CMD_LAST  = 4'd15;
  localparam int FIELD_MAX      = pcf_pkg::MAX_WIDTH_DEF;
  localparam int LINE_MAX       = pcf_pkg::MAX_WIDTH_DEF + 2;
  localparam int PTR_DIGITS     = (pcf_pkg::VALUE_BITS_DEF + 3) / 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 100;
  localparam int LONG_HOLD      = 250;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] value;
    logic [5:0]  width;
    logic        zf;
    logic        lj;
    logic [7:0]  other;
  } conv_item_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } out_char_t;

  typedef logic [7:0] char_q_t[$];

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [3:0]  cmd_i;
  logic [31:0] value_i;
  logic [5:0]  width_i;
  logic        zpad_i;
  logic        left_justify_i;
  logic [7:0]  other_char_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_char_o;
  logic        last_o;

  out_char_t expected_chars[$];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  int        hold_len = 0;
  bit        tx_idle = 1'b1;
  bit        rx_idle = 1'b1;

  printf_conversion_formatter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .value_i        (value_i),
    .width_i        (width_i),
    .zpad_i         (zpad_i),
    .left_justify_i (left_justify_i),
    .other_char_i   (other_char_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_o     (out_char_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // digits of v in the given radix, most significant first
  function automatic char_q_t spell_number(input logic [31:0] v, input logic [31:0] radix,
                                           input bit upper);
    char_q_t    digs;
    string      tab;
    logic [31:0] r;
    tab = upper ? "0123456789ABCDEF" : "0123456789abcdef";
    r = v;
    do begin
      digs.push_front(tab[r % radix]);
      r = r / radix;
    end while (r != 0);
    return digs;
  endfunction

  // queues the characters one conversion must produce
  function automatic void format_conversion(input conv_item_t it);
    char_q_t     digs;
    char_q_t     line;
    logic [31:0] mag;
    int          w;
    int          pad;
    int          n;
    bit          zf;
    bit          neg;
    out_char_t   oc;
    w   = (it.width > FIELD_MAX) ? FIELD_MAX : int'(it.width);
    zf  = it.zf;
    neg = 1'b0;
    mag = it.value;
    case (it.cmd)
      pcf_pkg::CMD_DEC: begin
        if (mag[31]) begin
          neg = 1'b1;
          mag = -mag;
        end
        digs = spell_number(mag, 10, 1'b0);
      end
      pcf_pkg::CMD_UDEC:  digs = spell_number(mag, 10, 1'b0);
      pcf_pkg::CMD_HEX_L: digs = spell_number(mag, 16, 1'b0);
      pcf_pkg::CMD_HEX_U: digs = spell_number(mag, 16, 1'b1);
      pcf_pkg::CMD_PTR: begin
        line.push_back("0");
        line.push_back("x");
        zf = 1'b1;
        w = PTR_DIGITS;
        digs = spell_number(mag, 16, 1'b0);
      end
      pcf_pkg::CMD_BIN: begin
        n = (w == 0) ? pcf_pkg::VALUE_BITS_DEF : w;
        if (n > pcf_pkg::VALUE_BITS_DEF) n = pcf_pkg::VALUE_BITS_DEF;
        for (int i = 0; i < n; i++) digs.push_back(mag[i] ? "1" : ".");
        w = n;
      end
      pcf_pkg::CMD_CHR: begin
        oc.code = it.value[7:0];
        oc.last = 1'b1;
        expected_chars.push_back(oc);
        return;
      end
      pcf_pkg::CMD_PCT: line.push_back("%");
      default: begin
        line.push_back("%");
        line.push_back(it.other);
      end
    endcase
    pad = w - digs.size() - (neg ? 1 : 0);
    if (zf && neg) begin
      line.push_back("-");
      neg = 1'b0;
    end
    if (!it.lj) begin
      for (; pad > 0; pad--) line.push_back(zf ? "0" : " ");
    end
    if (neg) line.push_back("-");
    foreach (digs[i]) line.push_back(digs[i]);
    if (it.lj) begin
      for (; pad > 0; pad--) line.push_back(" ");
    end
    n = (line.size() > LINE_MAX) ? LINE_MAX : line.size();
    for (int i = 0; i < n; i++) begin
      oc.code = line[i];
      oc.last = (i == n - 1);
      expected_chars.push_back(oc);
    end
  endfunction

  function automatic conv_item_t make_conv(input logic [3:0] cmd, input logic [31:0] value,
                                           input logic [5:0] width, input bit zf, input bit lj,
                                           input logic [7:0] other);
    conv_item_t it;
    it.cmd   = cmd;
    it.value = value;
    it.width = width;
    it.zf    = zf;
    it.lj    = lj;
    it.other = other;
    return it;
  endfunction

  function automatic conv_item_t random_conv();
    conv_item_t it;
    int         sel;
    sel = $urandom_range(0, 99);
    it.cmd = (sel < 90) ? 4'($urandom_range(pcf_pkg::CMD_DEC, CMD_OTHER))
                        : 4'($urandom_range(CMD_OTHER + 1, CMD_LAST));
    case ($urandom_range(0, 4))
      0: it.value = $urandom_range(0, 20);
      1: it.value = $urandom >> $urandom_range(0, 31);
      2: begin
        case ($urandom_range(0, 3))
          0: it.value = 32'h0000_0000;
          1: it.value = 32'hFFFF_FFFF;
          2: it.value = 32'h8000_0000;
          default: it.value = 32'h7FFF_FFFF;
        endcase
      end
      3: it.value = -($urandom_range(1, 100000));
      default: it.value = $urandom;
    endcase
    sel = $urandom_range(0, 99);
    if (sel < 70) it.width = 6'($urandom_range(0, 12));
    else if (sel < 92) it.width = 6'($urandom_range(0, FIELD_MAX));
    else it.width = 6'($urandom_range(0, 63));
    it.zf    = 1'($urandom_range(0, 1));
    it.lj    = 1'($urandom_range(0, 1));
    it.other = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch: %s", msg);
  endtask

  task automatic send_conv(input conv_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i          <= it.cmd;
    value_i        <= it.value;
    width_i        <= it.width;
    zpad_i         <= it.zf;
    left_justify_i <= it.lj;
    other_char_i   <= it.other;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    format_conversion(it);
  endtask

  // drops valid in the step of the last acceptance, then waits out every character
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_conv(make_conv(pcf_pkg::CMD_DEC, 32'd0, 6'd0, 1'b0, 1'b0, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_DEC, 32'h8000_0000, 6'd0, 1'b0, 1'b0, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_DEC, 32'hFFFF_FFFF, 6'd12, 1'b1, 1'b0, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_DEC, -32'd1234, 6'd10, 1'b0, 1'b1, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_DEC, -32'd1234, 6'd10, 1'b1, 1'b1, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_DEC, 32'h7FFF_FFFF, 6'd0, 1'b0, 1'b0, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_UDEC, 32'hFFFF_FFFF, 6'd60, 1'b1, 1'b0, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_UDEC, 32'd42, 6'd63, 1'b0, 1'b0, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_HEX_L, 32'hDEAD_BEEF, 6'd0, 1'b0, 1'b0, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_HEX_U, 32'h00AB_CDEF, 6'd10, 1'b1, 1'b0, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_HEX_L, 32'd0, 6'd3, 1'b0, 1'b1, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_PTR, 32'd0, 6'd0, 1'b0, 1'b0, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_PTR, 32'h0000_001F, 6'd30, 1'b0, 1'b1, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_PTR, 32'hCAFE_F00D, 6'd5, 1'b1, 1'b0, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_BIN, 32'hA5A5_0F0F, 6'd0, 1'b0, 1'b0, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_BIN, 32'h0000_0001, 6'd45, 1'b1, 1'b1, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_BIN, 32'h0000_0005, 6'd5, 1'b0, 1'b0, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_BIN, 32'hFFFF_FFFF, 6'd63, 1'b0, 1'b1, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_CHR, 32'hFFFF_FF41, 6'd0, 1'b0, 1'b0, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_CHR, 32'h0000_0000, 6'd40, 1'b1, 1'b0, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_PCT, 32'd0, 6'd0, 1'b0, 1'b0, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_PCT, 32'd0, 6'd5, 1'b1, 1'b0, 8'h00));
    send_conv(make_conv(pcf_pkg::CMD_PCT, 32'd0, 6'd60, 1'b1, 1'b1, 8'h00));
    // longest conversion: percent, echoed char and a full pad
    send_conv(make_conv(CMD_OTHER, 32'd0, 6'd63, 1'b0, 1'b0, 8'hFF));
    send_conv(make_conv(CMD_LAST, 32'hFFFF_FFFF, 6'd0, 1'b1, 1'b0, 8'h00));
    drain_results();
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) send_conv(random_conv());
    drain_results();
  endtask

  task automatic test_no_idle(input int count);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int i = 0; i < count; i++) send_conv(random_conv());
    drain_results();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // receiver holds off while items keep coming, so the input side backs up
  task automatic test_backpressure(input int count);
    hold_len = LONG_HOLD;
    for (int i = 0; i < count; i++) send_conv(random_conv());
    drain_results();
  endtask

  initial begin : stimulus
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    cmd_i          <= pcf_pkg::CMD_DEC;
    value_i        <= '0;
    width_i        <= '0;
    zpad_i         <= 1'b0;
    left_justify_i <= 1'b0;
    other_char_i   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_mix(220);
    test_no_idle(80);
    test_backpressure(6);
    test_random_mix(140);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : receiver
    int n;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end
      n = rx_idle ? $urandom_range(0, 6) : 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o && hold_len == 0);
    end
  end

  always @(posedge clk_i) begin
    out_char_t exp_c;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %02h last %0b", out_char_o, last_o));
      end else begin
        exp_c = expected_chars.pop_front();
        if (out_char_o !== exp_c.code)
          report_mismatch($sformatf("char got %02h expected %02h", out_char_o, exp_c.code));
        if (last_o !== exp_c.last)
          report_mismatch($sformatf("last got %0b expected %0b on char %02h",
                                    last_o, exp_c.last, exp_c.code));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
